/* design/rmlt_pkg.sv */
// Shared types and codes for the reentrant monitor lock table.
package rmlt_pkg;

  localparam int OBJ_REF_W = 32;
  localparam int THR_ID_W  = 8;
  localparam int STATUS_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED  = 3'd0,
    ST_REENTERED = 3'd1,
    ST_BLOCKED   = 3'd2,
    ST_NULL      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_ILLEGAL   = 3'd5,
    ST_NOT_HELD  = 3'd6,
    ST_FULL      = 3'd7
  } status_t;

  // Update broadcast to every cell once a lookup has finished
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_INCR    = 2'd2,
    OP_EXIT    = 2'd3
  } op_t;

  // Lookup token handed from one cell to the next
  typedef struct packed {
    logic tok;
    logic hit;
    logic owner_eq;
    logic cnt_max;
    logic free_seen;
  } link_t;

endpackage

/* design/rmlt_if.sv */
// Request and result channel interfaces for the lock table.
interface rmlt_req_if;
  import rmlt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [OBJ_REF_W-1:0] object_ref;
  logic [THR_ID_W-1:0]  thread_id;

  modport source (output valid, output mode, output object_ref, output thread_id,
                  input ready);
  modport sink   (input valid, input mode, input object_ref, input thread_id,
                  output ready);
endinterface

interface rmlt_res_if;
  import rmlt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                advance;
  logic                drop_priority;

  modport source (output valid, output status, output advance, output drop_priority,
                  input ready);
  modport sink   (input valid, input status, input advance, input drop_priority,
                  output ready);
endinterface

/* design/reentrant_monitor_lock_table_top.sv */
// Reentrant monitor lock table: top level with request control and cell chain.
//
// in_chan carries monitor requests (mode 0 enter, 1 exit, object_ref, thread_id);
// out_chan returns one result per request (status, advance, drop_priority).
// A transfer happens on a rising edge with valid and ready both high.
// A request with a non-null object sends a lookup token down a row of ENTRIES
// cells, one cell per cycle; each cell compares its entry and marks itself as the
// hit or as the lowest free entry. At the end of the row the result is decided
// and one update is broadcast to every cell; only the marked cell applies it.
// A non-null request walks the cell row, is decided into the pending result
// register (S_PEND) and then moves into the output register that drives
// out_chan.valid; a null reference skips the walk. One request is in flight at a
// time; in_chan.ready returns at the edge that moves the result into the output
// register, so a new request is taken only once the last one has left S_PEND.
// Reset (synchronous, rst_n low) empties the table, returns to idle and clears out_chan.valid.
// While out_chan.ready is low the result holds in the output register; a further
// request may be accepted and looked up, and its result waits until the
// register frees up.
module reentrant_monitor_lock_table_top #(
  parameter int ENTRIES     = 16,
  parameter int OBJECT_BITS = 32,
  parameter int THREAD_BITS = 8,
  parameter int COUNT_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rmlt_req_if.sink   in_chan,
  rmlt_res_if.source out_chan
);
  import rmlt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PEND
  } state_t;

  state_t                 state_r;
  logic                   start_r;
  logic                   req_exit_r;
  logic [OBJECT_BITS-1:0] req_obj_r;
  logic [THREAD_BITS-1:0] req_thr_r;
  op_t                    cmd_r;
  status_t                pend_status_r;
  logic                   pend_adv_r;
  logic                   pend_drop_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic                   out_adv_r;
  logic                   out_drop_r;

  logic [63:0]            obj_wide;
  logic [15:0]            thr_wide;
  logic [OBJECT_BITS-1:0] in_obj;
  logic [THREAD_BITS-1:0] in_thr;

  link_t                  links [ENTRIES+1];
  link_t                  last;

  status_t                dec_status;
  logic                   dec_adv;
  logic                   dec_drop;
  op_t                    dec_op;

  assign obj_wide = 64'(in_chan.object_ref);
  assign thr_wide = 16'(in_chan.thread_id);
  assign in_obj   = obj_wide[OBJECT_BITS-1:0];
  assign in_thr   = thr_wide[THREAD_BITS-1:0];

  always_comb begin
    links[0]     = '0;
    links[0].tok = start_r;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rmlt_cell #(
      .OBJECT_BITS (OBJECT_BITS),
      .THREAD_BITS (THREAD_BITS),
      .COUNT_BITS  (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .req_obj  (req_obj_r),
      .req_thr  (req_thr_r),
      .cmd_op   (cmd_r)
    );
  end

  assign last = links[ENTRIES];

  // Decide the outcome from the summary token leaving the last cell
  always_comb begin
    dec_status = ST_FULL;
    dec_adv    = 1'b0;
    dec_drop   = 1'b0;
    dec_op     = OP_NONE;
    if (!req_exit_r) begin
      if (last.hit) begin
        if (!last.owner_eq) begin
          dec_status = ST_BLOCKED;
          dec_drop   = 1'b1;
        end else if (!last.cnt_max) begin
          dec_status = ST_REENTERED;
          dec_adv    = 1'b1;
          dec_op     = OP_INCR;
        end
      end else if (last.free_seen) begin
        dec_status = ST_ACQUIRED;
        dec_adv    = 1'b1;
        dec_op     = OP_ACQUIRE;
      end
    end else begin
      if (!last.hit) begin
        dec_status = ST_NOT_HELD;
      end else if (!last.owner_eq) begin
        dec_status = ST_ILLEGAL;
      end else begin
        dec_status = ST_RELEASED;
        dec_adv    = 1'b1;
        dec_op     = OP_EXIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      cmd_r       <= OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= (state_r == S_IDLE) && in_chan.valid && (in_obj != '0);
      cmd_r   <= (state_r == S_WALK && last.tok) ? dec_op : OP_NONE;
      // drop the result once taken, unless a pending one replaces it
      if (out_valid_r && out_chan.ready && state_r != S_PEND) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            req_exit_r <= in_chan.mode;
            req_obj_r  <= in_obj;
            req_thr_r  <= in_thr;
            if (in_obj == '0) begin
              pend_status_r <= ST_NULL;
              pend_adv_r    <= 1'b0;
              pend_drop_r   <= 1'b0;
              state_r       <= S_PEND;
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (last.tok) begin
            pend_status_r <= dec_status;
            pend_adv_r    <= dec_adv;
            pend_drop_r   <= dec_drop;
            state_r       <= S_PEND;
          end
        end
        S_PEND: begin
          // hold until the output register is free
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= pend_status_r;
            out_adv_r    <= pend_adv_r;
            out_drop_r   <= pend_drop_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.advance       = out_adv_r;
  assign out_chan.drop_priority = out_drop_r;

endmodule

/* design/rmlt_cell.sv */
// One lock table entry with its stage of the lookup chain.
module rmlt_cell #(
  parameter int OBJECT_BITS = 32,
  parameter int THREAD_BITS = 8,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmlt_pkg::link_t        link_in,
  output rmlt_pkg::link_t        link_out,
  input  logic [OBJECT_BITS-1:0] req_obj,
  input  logic [THREAD_BITS-1:0] req_thr,
  input  rmlt_pkg::op_t          cmd_op
);
  import rmlt_pkg::*;

  logic                   valid_r;
  logic [OBJECT_BITS-1:0] obj_r;
  logic [THREAD_BITS-1:0] owner_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic                   sel_r;
  logic                   fsel_r;
  link_t                  link_r;
  link_t                  link_nxt;
  logic                   hit;

  assign hit = valid_r && (obj_r == req_obj);

  always_comb begin
    link_nxt = link_in;
    // objects are unique in the table, so at most one cell hits
    if (hit) begin
      link_nxt.hit      = 1'b1;
      link_nxt.owner_eq = (owner_r == req_thr);
      link_nxt.cnt_max  = &count_r;
    end
    link_nxt.free_seen = link_in.free_seen | ~valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
      fsel_r  <= 1'b0;
      link_r  <= '0;
    end else begin
      link_r <= link_nxt;
      if (link_in.tok) begin
        sel_r  <= hit;
        fsel_r <= ~valid_r & ~link_in.free_seen;
      end
      case (cmd_op)
        OP_ACQUIRE: if (fsel_r) valid_r <= 1'b1;
        OP_EXIT:    if (sel_r && count_r <= COUNT_BITS'(1)) valid_r <= 1'b0;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd_op)
      OP_ACQUIRE: begin
        if (fsel_r) begin
          obj_r   <= req_obj;
          owner_r <= req_thr;
          count_r <= COUNT_BITS'(1);
        end
      end
      OP_INCR: if (sel_r) count_r <= count_r + COUNT_BITS'(1);
      OP_EXIT: if (sel_r) count_r <= count_r - COUNT_BITS'(1);
      default: ;
    endcase
  end

  assign link_out = link_r;

endmodule

/* design/rmlt_checker.sv */
// Port-level checks for the lock table, bound to the top level.
module rmlt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rmlt_pkg::STATUS_W-1:0] out_status,
  input logic                          out_advance,
  input logic                          out_drop_priority
);
  import rmlt_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_advance)
                                && $stable(out_drop_priority))
    else $error("result changed while stalled");

  // one request in flight: ready drops after each input transfer
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_drop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop_priority |-> out_status == ST_BLOCKED && !out_advance)
    else $error("priority drop without a blocked status");

  a_adv_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_advance |-> out_status == ST_ACQUIRED
                                 || out_status == ST_REENTERED
                                 || out_status == ST_RELEASED)
    else $error("advance on a status that does not complete the instruction");

endmodule

bind reentrant_monitor_lock_table_top rmlt_checker u_rmlt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_advance       (out_chan.advance),
  .out_drop_priority (out_chan.drop_priority)
);
